// ----- sv/ist_pkg.sv -----
// Package for the integer set table: request codes and the beat types of
// the request and result channels. No dependencies.
package ist_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  // The spare selector behaves as a membership query.
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic               was_present;
    logic [COUNT_W-1:0] element_count;
    logic               rejected_full;
  } out_t;

endpackage

// ----- sv/integer_set_table.sv -----
// Integer set table: unordered set of distinct 32-bit values, one memory
// scanned by a single compare unit. Depends on ist_pkg.
// Scan: reads one held entry per cycle; a remove that hits then fetches the last
// entry and moves it into the freed slot.
// Flow: one request at a time; a new one is taken only after the result is loaded.
// Reset: rst_n, synchronous, empties the set; memory contents are not cleared.
module integer_set_table #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ist_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ist_pkg::out_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FETCH = 5'b00100,
    S_MOVE  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  logic [ist_pkg::VALUE_W-1:0] mem [DEPTH];

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CNT_W-1:0]            issue_idx_r, issue_idx_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]            rd_idx_r;
  logic [ist_pkg::VALUE_W-1:0] rd_data_r;
  logic [1:0]                  req_r;
  logic [ist_pkg::VALUE_W-1:0] val_r;
  logic                        present_r, present_nxt;
  logic                        reject_r, reject_nxt;
  logic [IDX_W-1:0]            slot_r, slot_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ist_pkg::out_t               out_r;

  logic                        issue;
  logic                        hit;
  logic [IDX_W-1:0]            rd_addr;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [ist_pkg::VALUE_W-1:0] wr_data;
  logic                        load_out;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign issue    = (issue_idx_r != count_r);
  assign hit      = rd_vld_r && (rd_data_r == val_r);
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_idx_nxt = issue_idx_r;
    rd_vld_nxt    = 1'b0;
    present_nxt   = present_r;
    reject_nxt    = reject_r;
    slot_nxt      = slot_r;
    rd_addr       = issue_idx_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = slot_r;
    wr_data       = rd_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt     = S_SCAN;
          issue_idx_nxt = '0;
          present_nxt   = 1'b0;
          reject_nxt    = 1'b0;
        end
      end
      S_SCAN: begin
        if (hit) begin
          present_nxt = 1'b1;
          slot_nxt    = rd_idx_r;
          if (req_r == ist_pkg::REQ_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (!issue && !rd_vld_r) begin
          // Scan finished without a match.
          state_nxt = S_DONE;
          if (req_r == ist_pkg::REQ_INSERT) begin
            if (count_r == FULL_CNT) begin
              reject_nxt = 1'b1;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = count_r[IDX_W-1:0];
              wr_data   = val_r;
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end else if (issue) begin
          rd_vld_nxt    = 1'b1;
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
        end
      end
      S_FETCH: begin
        // The count has already dropped, so it now points at the last entry.
        rd_addr   = count_r[IDX_W-1:0];
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        wr_en     = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_idx_r <= issue_idx_nxt;
    rd_idx_r    <= issue_idx_r[IDX_W-1:0];
    present_r   <= present_nxt;
    reject_r    <= reject_nxt;
    slot_r      <= slot_nxt;
    if (in_valid && in_ready) begin
      req_r <= in_data.req_type;
      val_r <= $unsigned(in_data.item_value);
    end
    if (load_out) begin
      out_r.was_present   <= present_r;
      out_r.element_count <= ist_pkg::COUNT_W'(count_r);
      out_r.rejected_full <= reject_r;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a previous one was in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("element count exceeds table depth");

  a_reject_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rejected_full |-> !out_data.was_present)
    else $error("rejection reported for a value already present");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == S_SCAN)
    else $error("scan read in flight outside the scan");
`endif

endmodule
